// ===== rtl/acp_pkg.sv =====
// Package for the automaton pattern counter: request and response types,
// command and sequencer encodings, sizes and row address helpers.
// No dependencies.
`default_nettype none

package acp_pkg;

  localparam int MAX_PATTERN = 256;
  localparam int ALPHABET    = 26;
  localparam int TAB_DEPTH   = (MAX_PATTERN + 1) * ALPHABET;
  localparam int TAB_AW      = $clog2(TAB_DEPTH);
  localparam int PAT_AW      = $clog2(MAX_PATTERN);
  localparam int ST_W        = $clog2(MAX_PATTERN + 1);
  localparam int SYM_W       = 5;
  localparam int LEN_W       = 9;
  localparam int CNT_W       = 32;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_TEXT    = 2'd1,
    CMD_RESTART = 2'd2
  } acp_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAT_RD,
    ST_TAB_RD,
    ST_TAB_WR,
    ST_TEXT
  } acp_state_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [SYM_W-1:0]  symbol;
    logic [PAT_AW-1:0] pattern_index;
  } acp_req_t;

  typedef struct packed {
    logic             match;
    logic [CNT_W-1:0] match_count;
  } acp_resp_t;

  typedef struct packed {
    logic              pat_we;
    logic [PAT_AW-1:0] pat_waddr;
    logic [SYM_W-1:0]  pat_wdata;
    logic [PAT_AW-1:0] pat_raddr;
    logic              tab_we;
    logic [TAB_AW-1:0] tab_waddr;
    logic [ST_W-1:0]   tab_wdata;
    logic [TAB_AW-1:0] tab_raddr;
  } acp_mem_req_t;

  function automatic logic [TAB_AW-1:0] row_base(input logic [ST_W-1:0] row);
    return TAB_AW'(row) * TAB_AW'(ALPHABET);
  endfunction

  function automatic logic [ST_W-1:0] eff_length(input logic [LEN_W-1:0] len);
    logic [ST_W-1:0] n;
    if (len == '0) begin
      n = ST_W'(1);
    end else if (32'(len) > MAX_PATTERN) begin
      n = ST_W'(MAX_PATTERN);
    end else begin
      n = ST_W'(len);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/acp_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module acp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/acp_ctrl.sv =====
// Sequencer and datapath: request decode, table build sweep, text lookup,
// running count and output register. Depends on acp_pkg.
`default_nettype none

module acp_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [acp_pkg::LEN_W-1:0]  cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire acp_pkg::acp_req_t          in_req_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output acp_pkg::acp_resp_t              out_resp_o,
  output acp_pkg::acp_mem_req_t           mem_o,
  input  wire logic [acp_pkg::SYM_W-1:0]  pat_rdata_i,
  input  wire logic [acp_pkg::ST_W-1:0]   tab_rdata_i
);

  import acp_pkg::*;

  acp_state_e         state_q, state_d;
  logic [LEN_W-1:0]   len_q;
  logic [ST_W-1:0]    k_q, k_d;
  logic [SYM_W-1:0]   c_q, c_d;
  logic [TAB_AW-1:0]  waddr_q, waddr_d;
  logic [TAB_AW-1:0]  base_q, base_d;
  logic [ST_W-1:0]    newback_q, newback_d;
  logic [SYM_W-1:0]   sym_q, sym_d;
  logic [ST_W-1:0]    auto_q, auto_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               out_valid_q, out_valid_d;
  acp_resp_t          resp_q, resp_d;

  logic [ST_W-1:0]    len_eff;
  logic [PAT_AW-1:0]  len_m1;
  logic [ST_W-1:0]    auto_row;
  logic [SYM_W-1:0]   sym_safe;
  logic               is_sym;
  logic [ST_W-1:0]    nb;
  logic [ST_W-1:0]    nxt;
  logic               hit;
  logic               sym_ok;

  assign len_eff     = eff_length(len_q);
  assign len_m1      = PAT_AW'(len_eff - ST_W'(1));
  assign auto_row    = (32'(auto_q) > MAX_PATTERN) ? '0 : auto_q;
  assign sym_safe    = (32'(in_req_i.symbol) < ALPHABET) ? in_req_i.symbol : '0;
  assign is_sym      = (pat_rdata_i == c_q);
  assign sym_ok      = (32'(sym_q) < ALPHABET);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_resp_o  = resp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= LEN_W'(1);
      auto_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      auto_q      <= auto_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    c_q       <= c_d;
    waddr_q   <= waddr_d;
    base_q    <= base_d;
    newback_q <= newback_d;
    sym_q     <= sym_d;
    resp_q    <= resp_d;
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    c_d         = c_q;
    waddr_d     = waddr_q;
    base_d      = base_q;
    newback_d   = newback_q;
    sym_d       = sym_q;
    auto_d      = auto_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    resp_d      = resp_q;
    nb          = newback_q;
    nxt         = '0;
    hit         = 1'b0;

    mem_o           = '0;
    mem_o.pat_raddr = k_q[PAT_AW-1:0];
    mem_o.tab_raddr = base_q + TAB_AW'(c_q);
    mem_o.tab_waddr = waddr_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_req_i.cmd)
            CMD_LOAD: begin
              mem_o.pat_we    = 1'b1;
              mem_o.pat_waddr = in_req_i.pattern_index;
              mem_o.pat_wdata = in_req_i.symbol;
              if (in_req_i.pattern_index == len_m1) begin
                k_d     = '0;
                base_d  = '0;
                waddr_d = '0;
                state_d = ST_PAT_RD;
              end
            end
            CMD_TEXT: begin
              sym_d           = in_req_i.symbol;
              mem_o.tab_raddr = row_base(auto_row) + TAB_AW'(sym_safe);
              state_d         = ST_TEXT;
            end
            CMD_RESTART: begin
              auto_d  = '0;
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PAT_RD: begin
        newback_d = '0;
        c_d       = '0;
        state_d   = ST_TAB_RD;
      end
      ST_TAB_RD: begin
        state_d = ST_TAB_WR;
      end
      ST_TAB_WR: begin
        mem_o.tab_we = 1'b1;
        if (k_q == '0) begin
          mem_o.tab_wdata = is_sym ? ST_W'(1) : '0;
        end else if ((k_q < len_eff) && is_sym) begin
          mem_o.tab_wdata = k_q + ST_W'(1);
        end else begin
          mem_o.tab_wdata = tab_rdata_i;
        end
        waddr_d = waddr_q + TAB_AW'(1);
        if (is_sym) begin
          newback_d = tab_rdata_i;
        end
        if (32'(c_q) == ALPHABET - 1) begin
          if (k_q == len_eff) begin
            auto_d  = '0;
            count_d = '0;
            state_d = ST_IDLE;
          end else begin
            if (k_q != '0) begin
              nb     = is_sym ? tab_rdata_i : newback_q;
              base_d = row_base(nb);
            end
            k_d     = k_q + ST_W'(1);
            state_d = ST_PAT_RD;
          end
        end else begin
          c_d     = c_q + SYM_W'(1);
          state_d = ST_TAB_RD;
        end
      end
      ST_TEXT: begin
        mem_o.tab_raddr = row_base(auto_row) + TAB_AW'(sym_ok ? sym_q : '0);
        if (!(out_valid_q && out_stall_i)) begin
          nxt = sym_ok ? tab_rdata_i : '0;
          hit = sym_ok && (nxt == len_eff);
          if (hit && (count_q != '1)) begin
            count_d = count_q + CNT_W'(1);
          end
          auto_d             = nxt;
          resp_d.match       = hit;
          resp_d.match_count = count_d;
          out_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/automaton_pattern_counter.sv =====
// Top level of the automaton pattern counter: sequencer plus pattern and
// transition RAMs. Depends on acp_pkg, acp_ram and acp_ctrl.
//
//  channel | signals                          | dir | accepted when
//  --------+----------------------------------+-----+------------------------
//  request | in_valid_i, in_stall_o, in_req_i | in  | in_valid_i & !in_stall_o
//  result  | out_valid_o, out_stall_i, resp   | out | out_valid_o & !out_stall_i
//  config  | cfg_we_i, cfg_wdata_i            | in  | cfg_we_i
//
// Load and restart are handled in idle; a text symbol passes through request and
// table read. A load at the last pattern position starts the build sweep over the
// transition RAM: per row a pattern read, then a read and a write for each entry.
// The result register frees the request side; a text request waits in its
// lookup cycle only while an earlier result is still stalled.
// Reset clears control, length (to 1), state and count; the RAMs are not cleared.
`default_nettype none

module automaton_pattern_counter (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [acp_pkg::LEN_W-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire acp_pkg::acp_req_t         in_req_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output acp_pkg::acp_resp_t             out_resp_o
);

  import acp_pkg::*;

  acp_mem_req_t      mem;
  logic [SYM_W-1:0]  pat_rdata;
  logic [ST_W-1:0]   tab_rdata;

  acp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_resp_o  (out_resp_o),
    .mem_o       (mem),
    .pat_rdata_i (pat_rdata),
    .tab_rdata_i (tab_rdata)
  );

  acp_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_PATTERN)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (mem.pat_we),
    .waddr_i (mem.pat_waddr),
    .wdata_i (mem.pat_wdata),
    .raddr_i (mem.pat_raddr),
    .rdata_o (pat_rdata)
  );

  acp_ram #(
    .WIDTH (ST_W),
    .DEPTH (TAB_DEPTH)
  ) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (mem.tab_we),
    .waddr_i (mem.tab_waddr),
    .wdata_i (mem.tab_wdata),
    .raddr_i (mem.tab_raddr),
    .rdata_o (tab_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/acp_checker.sv =====
// Port-level checker for the automaton pattern counter, bound to the top level.
// Depends on acp_pkg.
`default_nettype none

module acp_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_stall_o,
  input wire acp_pkg::acp_req_t         in_req_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire acp_pkg::acp_resp_t        out_resp_o
);

  import acp_pkg::*;

  logic text_acc;

  assign text_acc = in_valid_i && !in_stall_o && (in_req_i.cmd == CMD_TEXT);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_resp_o))
    else $error("stalled result changed");

  a_match_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_resp_o.match |-> out_resp_o.match_count != '0)
    else $error("match with zero count");

  a_text_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_acc |=> in_stall_o)
    else $error("text request not held for lookup");

  a_text_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_acc |=> ##1 out_valid_o)
    else $error("no result after text request");

endmodule

bind automaton_pattern_counter acp_checker u_acp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_resp_o  (out_resp_o)
);

`default_nettype wire
